@@ design/per_flow_read_rate_limiter_unit_assert.svh @@
// assertion macros for the per-flow read rate limiter checker
// expects clk and arst_n in the scope of each use
`ifndef PER_FLOW_READ_RATE_LIMITER_UNIT_ASSERT_SVH
`define PER_FLOW_READ_RATE_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication
`define RFL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rate limiter assertion failed");

// next-cycle implication
`define RFL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rate limiter assertion failed");

`endif

@@ design/rfl_pkg.sv @@
// shared types, codes and sizes for the per-flow read rate limiter
// no dependencies
package rfl_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE  = 2'd2;

	localparam logic [7:0]  WINDOW_RST = 8'd2;
	localparam logic [31:0] LIMIT_RST  = 32'd10485760;
	localparam logic [15:0] STALE_RST  = 16'd10;

	localparam logic [1:0] ALU_AGE_GT  = 2'd0;
	localparam logic [1:0] ALU_AGE_GE  = 2'd1;
	localparam logic [1:0] ALU_SAT_ADD = 2'd2;

	typedef struct packed {
		logic [21:0] proc_id;
		logic [31:0] now_seconds;
		logic [20:0] transfer_bytes;
	} req_t;

	typedef struct packed {
		logic        refused;
		logic        tripped;
		logic        untracked;
		logic [31:0] window_total;
	} rsp_t;

	typedef struct packed {
		logic [21:0] id;
		logic [31:0] start;
		logic [31:0] total;
		logic        blocked;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} alu_cmd_t;

	typedef struct packed {
		logic [31:0] res;
		logic        flag;
	} alu_res_t;

endpackage

@@ design/rfl_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module rfl_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 87
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ design/rfl_alu.sv @@
// shared arithmetic unit: clamped age compare and saturating add with limit compare
// depends on rfl_pkg
module rfl_alu (
	input  rfl_pkg::alu_cmd_t cmd,
	output rfl_pkg::alu_res_t result
);
	import rfl_pkg::*;

	logic [32:0] diff;
	logic [32:0] sum;
	logic [31:0] age;
	logic [31:0] sat;

	always_comb begin
		diff = {1'b0, cmd.a} - {1'b0, cmd.b};
		sum  = {1'b0, cmd.a} + {1'b0, cmd.b};
		age  = diff[32] ? 32'd0 : diff[31:0];
		sat  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		unique case (cmd.op)
			ALU_AGE_GT: begin
				result.res  = age;
				result.flag = age > cmd.c;
			end
			ALU_AGE_GE: begin
				result.res  = age;
				result.flag = age >= cmd.c;
			end
			ALU_SAT_ADD: begin
				result.res  = sat;
				result.flag = sat > cmd.c;
			end
			default: begin
				result.res  = 32'd0;
				result.flag = 1'b0;
			end
		endcase
	end

endmodule

@@ design/per_flow_read_rate_limiter_unit.sv @@
// per-flow read rate limiter, top level; depends on rfl_pkg, rfl_ram, rfl_alu
// a response follows a scan that stops at the matching entry, or runs through the whole
// table when a free entry is taken or the request stays untracked
// one request per scan, plus any response stall before its result is registered
// reset: a clearing pass frees all TABLE_ENTRIES (1024) entries, one per cycle,
// while req_stall stays high; config registers take their reset values at once
module per_flow_read_rate_limiter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  rfl_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output rfl_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	import rfl_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_WIN   = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic             issue_q;
	logic             chk_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	logic             have_free_q;
	logic [IDX_W-1:0] free_idx_q;
	req_t             req_q;
	logic [IDX_W-1:0] slot_q;
	logic [31:0]      slot_start_q;
	logic [31:0]      slot_total_q;
	logic             slot_blocked_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic [7:0]       win_q;
	logic [31:0]      limit_q;
	logic [15:0]      stale_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             row;

	alu_cmd_t alu_cmd;
	alu_res_t alu_res;

	logic             idx_last;
	logic             chk_last;
	logic             match;
	logic             free_hit;
	logic             first_free;
	logic             stale;
	logic             any_free;
	logic             claim;
	logic [IDX_W-1:0] end_free_idx;
	logic             add_en;
	logic [31:0]      new_total;
	logic             new_trip;
	logic             new_blocked;
	logic             out_free;

	rfl_ram #(
		.DEPTH(TABLE_ENTRIES),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (idx_q),
		.rd_data (ram_rdata)
	);

	rfl_alu u_alu (
		.cmd    (alu_cmd),
		.result (alu_res)
	);

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		row          = entry_t'(ram_rdata);
		idx_last     = idx_q == IDX_LAST;
		chk_last     = chk_idx_s1 == IDX_LAST;
		match        = chk_s1 && (req_q.proc_id != '0) && (row.id == req_q.proc_id);
		free_hit     = chk_s1 && (row.id == '0);
		first_free   = free_hit && !have_free_q;
		stale        = chk_s1 && (row.id != '0) && !match && alu_res.flag;
		any_free     = have_free_q || free_hit;
		claim        = (req_q.proc_id != '0) && any_free;
		end_free_idx = have_free_q ? free_idx_q : chk_idx_s1;
		add_en       = !slot_blocked_q && (req_q.transfer_bytes != '0);
		new_total    = add_en ? alu_res.res : slot_total_q;
		new_trip     = add_en && alu_res.flag;
		new_blocked  = slot_blocked_q || new_trip;
		out_free     = !rsp_valid_q || !rsp_stall;
		ram_re       = (state_q == ST_SCAN) && issue_q;
	end

	// one unit, operands chosen by sequencer step
	always_comb begin
		unique case (state_q)
			ST_WIN: begin
				alu_cmd.op = ALU_AGE_GE;
				alu_cmd.a  = req_q.now_seconds;
				alu_cmd.b  = slot_start_q;
				alu_cmd.c  = 32'(win_q);
			end
			ST_ADD: begin
				alu_cmd.op = ALU_SAT_ADD;
				alu_cmd.a  = slot_total_q;
				alu_cmd.b  = 32'(req_q.transfer_bytes);
				alu_cmd.c  = limit_q;
			end
			default: begin
				alu_cmd.op = ALU_AGE_GT;
				alu_cmd.a  = req_q.now_seconds;
				alu_cmd.b  = row.start;
				alu_cmd.c  = 32'(stale_q);
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_SCAN: begin
				ram_we    = stale;
				ram_waddr = chk_idx_s1;
			end
			ST_ADD: begin
				ram_we            = 1'b1;
				ram_waddr         = slot_q;
				ram_wdata.id      = req_q.proc_id;
				ram_wdata.start   = slot_start_q;
				ram_wdata.total   = new_total;
				ram_wdata.blocked = new_blocked;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			chk_s1      <= 1'b0;
			have_free_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			win_q       <= WINDOW_RST;
			limit_q     <= LIMIT_RST;
			stale_q     <= STALE_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_WINDOW: win_q   <= cfg_data[7:0];
					CFG_LIMIT:  limit_q <= cfg_data;
					CFG_STALE:  stale_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q     <= ST_SCAN;
						idx_q       <= '0;
						issue_q     <= 1'b1;
						chk_s1      <= 1'b0;
						have_free_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (first_free) begin
						have_free_q <= 1'b1;
					end
					if (match) begin
						state_q <= ST_WIN;
						chk_s1  <= 1'b0;
						issue_q <= 1'b0;
					end else if (chk_s1 && chk_last) begin
						chk_s1  <= 1'b0;
						state_q <= claim ? ST_WIN : ST_DONE;
					end else begin
						chk_s1 <= issue_q;
						if (issue_q) begin
							idx_q <= idx_q + 1'b1;
							if (idx_last) begin
								issue_q <= 1'b0;
							end
						end
					end
				end
				ST_WIN: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_SCAN) begin
			chk_idx_s1 <= idx_q;
			if (first_free) begin
				free_idx_q <= chk_idx_s1;
			end
			if (match) begin
				slot_q         <= chk_idx_s1;
				slot_start_q   <= row.start;
				slot_total_q   <= row.total;
				slot_blocked_q <= row.blocked;
			end else if (chk_s1 && chk_last) begin
				slot_q             <= end_free_idx;
				slot_start_q       <= req_q.now_seconds;
				slot_total_q       <= '0;
				slot_blocked_q     <= 1'b0;
				res_q.refused      <= 1'b0;
				res_q.tripped      <= 1'b0;
				res_q.untracked    <= 1'b1;
				res_q.window_total <= '0;
			end
		end
		// window elapsed: restart counting
		if (state_q == ST_WIN && alu_res.flag) begin
			slot_start_q   <= req_q.now_seconds;
			slot_total_q   <= '0;
			slot_blocked_q <= 1'b0;
		end
		if (state_q == ST_ADD) begin
			res_q.refused      <= slot_blocked_q;
			res_q.tripped      <= new_trip;
			res_q.untracked    <= 1'b0;
			res_q.window_total <= new_total;
		end
		if (state_q == ST_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

endmodule

@@ design/rfl_checker.sv @@
// port-level checks for the per-flow read rate limiter, bound to the top level
// depends on rfl_pkg and per_flow_read_rate_limiter_unit_assert.svh
`include "per_flow_read_rate_limiter_unit_assert.svh"

module rfl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input rfl_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input rfl_pkg::rsp_t rsp
);
	import rfl_pkg::*;

	`RFL_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall)
	`RFL_ASSERT_IMP(a_untracked_clean, rsp_valid && rsp.untracked, !rsp.refused && !rsp.tripped && rsp.window_total == 32'd0)
	`RFL_ASSERT_IMP(a_refuse_no_trip, rsp_valid && rsp.tripped, !rsp.refused && rsp.window_total != 32'd0)
	`RFL_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind per_flow_read_rate_limiter_unit rfl_checker u_rfl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

@@ bench/tb_per_flow_read_rate_limiter_unit.sv @@
// testbench for per_flow_read_rate_limiter_unit: directed and random request beats,
// every response beat checked against an in-bench copy of the flow table
// depends on rfl_pkg and the design top level
module tb_per_flow_read_rate_limiter_unit;
	import rfl_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int FLOW_POOL = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	class flow_budget_tracker;
		logic [21:0] slot_id [TABLE_ENTRIES];
		logic [31:0] slot_start [TABLE_ENTRIES];
		logic [31:0] slot_total [TABLE_ENTRIES];
		logic        slot_blocked [TABLE_ENTRIES];
		logic [7:0]  window_len;
		logic [31:0] limit;
		logic [15:0] stale_age;
		rsp_t        due_verdicts [$];
		int          mismatch_count;

		function new();
			foreach (slot_id[i]) begin
				slot_id[i] = '0;
				slot_start[i] = '0;
				slot_total[i] = '0;
				slot_blocked[i] = 1'b0;
			end
			window_len = WINDOW_RST;
			limit = LIMIT_RST;
			stale_age = STALE_RST;
			mismatch_count = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
			case (index)
				CFG_WINDOW: window_len = data[7:0];
				CFG_LIMIT:  limit = data;
				CFG_STALE:  stale_age = data[15:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] seconds_since(logic [31:0] now, logic [31:0] start);
			return (now >= start) ? now - start : '0;
		endfunction

		function void note_request(req_t item);
			rsp_t verdict;
			bit hit;
			bit have_free;
			int slot;
			int free_slot;
			logic [32:0] sum;
			verdict = '0;
			hit = 1'b0;
			have_free = 1'b0;
			slot = 0;
			free_slot = 0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (item.proc_id != '0 && slot_id[i] == item.proc_id) begin
					hit = 1'b1;
					slot = i;
					break;
				end
				if (slot_id[i] == '0) begin
					if (!have_free) begin
						have_free = 1'b1;
						free_slot = i;
					end
				end else if (seconds_since(item.now_seconds, slot_start[i]) > stale_age) begin
					slot_id[i] = '0;
					slot_start[i] = '0;
					slot_total[i] = '0;
					slot_blocked[i] = 1'b0;
				end
			end
			if (!hit && have_free && item.proc_id != '0) begin
				slot = free_slot;
				slot_id[slot] = item.proc_id;
				slot_start[slot] = item.now_seconds;
				slot_total[slot] = '0;
				slot_blocked[slot] = 1'b0;
				hit = 1'b1;
			end
			if (!hit) begin
				verdict.untracked = 1'b1;
			end else begin
				if (seconds_since(item.now_seconds, slot_start[slot]) >= window_len) begin
					slot_start[slot] = item.now_seconds;
					slot_total[slot] = '0;
					slot_blocked[slot] = 1'b0;
				end
				if (slot_blocked[slot]) begin
					verdict.refused = 1'b1;
				end else if (item.transfer_bytes != '0) begin
					sum = {1'b0, slot_total[slot]} + item.transfer_bytes;
					slot_total[slot] = sum[32] ? '1 : sum[31:0];
					if (slot_total[slot] > limit) begin
						slot_blocked[slot] = 1'b1;
						verdict.tripped = 1'b1;
					end
				end
				verdict.window_total = slot_total[slot];
			end
			due_verdicts.push_back(verdict);
		endfunction

		function void check_verdict(rsp_t got);
			rsp_t want;
			if (due_verdicts.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected response beat: r=%0b t=%0b u=%0b total=%0d",
						got.refused, got.tripped, got.untracked, got.window_total);
				return;
			end
			want = due_verdicts.pop_front();
			if (got.refused !== want.refused || got.tripped !== want.tripped ||
					got.untracked !== want.untracked ||
					got.window_total !== want.window_total) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("mismatch: want r=%0b t=%0b u=%0b total=%0d, got r=%0b t=%0b u=%0b total=%0d",
						want.refused, want.tripped, want.untracked, want.window_total,
						got.refused, got.tripped, got.untracked, got.window_total);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	flow_budget_tracker budget = new();
	logic [31:0] clock_now;
	logic [21:0] flow_ids [FLOW_POOL];
	int send_quiet = 0;
	int recv_quiet = 0;
	int idle_cycles = 0;

	per_flow_read_rate_limiter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			budget.check_verdict(rsp);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// quiet stretches give runs of back-to-back beats
	function automatic int draw_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic req_t beat_of(logic [21:0] id, logic [31:0] now, logic [20:0] bytes);
		req_t b;
		b.proc_id = id;
		b.now_seconds = now;
		b.transfer_bytes = bytes;
		return b;
	endfunction

	function automatic req_t next_item();
		req_t item;
		int pick;
		int step;
		int span;
		pick = $urandom_range(0, 19);
		item.proc_id = flow_ids[$urandom_range(0, FLOW_POOL - 1)];
		if (pick == 0)
			item.proc_id = ($urandom_range(0, 3) == 0) ? '0 : 22'($urandom);
		step = $urandom_range(0, 9);
		if (step >= 5 && step < 8)
			clock_now = clock_now + 1;
		else if (step == 8)
			clock_now = clock_now + budget.window_len;
		else if (step == 9)
			clock_now = clock_now + $urandom_range(0, 2 * budget.stale_age + 3);
		// time going backwards now and then
		item.now_seconds = (pick == 1) ? clock_now - $urandom_range(1, 5) : clock_now;
		if (budget.limit / 3 >= 1048576)
			span = 1048576;
		else
			span = budget.limit / 3 + 1;
		case ($urandom_range(0, 9))
			0: item.transfer_bytes = '0;
			1: item.transfer_bytes = 21'd1048576;
			2: item.transfer_bytes = 21'($urandom);
			default: item.transfer_bytes = 21'($urandom_range(0, span));
		endcase
		return item;
	endfunction

	task automatic send_request(input req_t item);
		int gap;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		budget.note_request(item);
	endtask

	task automatic receive_loop();
		int gap;
		forever begin
			gap = draw_gap(recv_quiet);
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!rsp_valid);
		end
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (budget.due_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [31:0] window_word, limit_word, stale_word);
		logic [CFG_IDX_W-1:0] order [4];
		logic [31:0] words [4];
		order = '{CFG_WINDOW, CFG_LIMIT, CFG_STALE, CFG_SPARE};
		words = '{window_word, limit_word, stale_word, $urandom};
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[k];
			cfg_data <= words[k];
			do @(posedge clk); while (!cfg_ready);
			budget.set_reg(order[k], words[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count);
		for (int k = 0; k < FLOW_POOL; k++)
			flow_ids[k] = 22'($urandom_range(1, 22'h3FFFFF));
		repeat (count) send_request(next_item());
		settle();
	endtask

	initial begin
		req_t plan [$];
		logic [31:0] t0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		clock_now = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		fork
			receive_loop();
		join_none

		// directed beats under reset settings
		t0 = 32'd1000;
		plan.push_back(beat_of(22'd1, t0, 21'd0));
		plan.push_back(beat_of(22'h3FFFFF, t0, 21'd1048576));
		plan.push_back(beat_of(22'd0, t0, 21'd1234));
		repeat (6) plan.push_back(beat_of(22'h2AAAAA, t0, 21'h1FFFFF));
		plan.push_back(beat_of(22'h2AAAAA, t0, 21'd1));
		plan.push_back(beat_of(22'h2AAAAA, t0 + 1, 21'd5));
		plan.push_back(beat_of(22'h2AAAAA, t0 + 2, 21'd0));
		plan.push_back(beat_of(22'h2AAAAA, t0 + 2, 21'd7));
		plan.push_back(beat_of(22'h2AAAAA, t0 + 1, 21'd3));
		// far jump frees everything stale in the same scan
		plan.push_back(beat_of(22'h155555, 32'hFFFF_FFFF, 21'd100));
		plan.push_back(beat_of(22'd1, 32'hFFFF_FFFF, 21'd50));
		plan.push_back(beat_of(22'd1, 32'd0, 21'd10));
		plan.push_back(beat_of(22'd2, 32'd0, 21'd1048576));
		plan.push_back(beat_of(22'd0, 32'd0, 21'd0));
		foreach (plan[k]) send_request(plan[k]);
		settle();

		clock_now = $urandom_range(0, 32'hF000_0000);
		run_random(80);
		write_regs(32'd1, 32'd1, 32'd1);
		run_random(96);
		write_regs(32'd255, 32'hFFFF_FFFF, 32'd65535);
		run_random(96);
		write_regs(32'd0, 32'd3000000, 32'd5);
		run_random(96);
		write_regs({24'($urandom), 8'($urandom_range(1, 8))},
			32'($urandom_range(1, 4000000)),
			{16'($urandom), 16'($urandom_range(1, 20))});
		run_random(96);
		write_regs(32'd3, 32'd2500000, 32'd12);
		run_random(96);

		repeat (TABLE_ENTRIES + 10) @(posedge clk);
		if (budget.mismatch_count == 0 && budget.due_verdicts.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
